// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("Assertion failed: same-cycle implication.");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("Assertion failed: next-cycle implication.");

`endif

// ----- rtl/core/cpcs_pkg.sv -----
// ----------------------------------------------------------------------------
// cpcs_pkg
// Types, constants and character classification for the character sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package cpcs_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 7;
    localparam int NUM_BINS    = 62;
    localparam int BIN_W       = 6;
    localparam int CNT_W       = 7;
    localparam int DIGIT_BINS  = 10;
    localparam int LETTER_BINS = 52;
    localparam int DCUR_W      = 4;
    localparam int LCUR_W      = 6;

    localparam logic [7:0] DIGIT0  = 8'd48;
    localparam logic [7:0] DIGIT9  = 8'd57;
    localparam logic [7:0] CHAR_LA = 8'd97;
    localparam logic [7:0] CHAR_LZ = 8'd122;
    localparam logic [7:0] CHAR_UA = 8'd65;
    localparam logic [7:0] CHAR_UZ = 8'd90;

    typedef struct packed {
        logic             hit;
        logic [BIN_W-1:0] bin;
    } bin_sel_t;

    // Digits map to bins 0..9, letters to 10..61 in the order a,A,b,B,...,z,Z.
    function automatic bin_sel_t bin_of(input logic [7:0] c);
        bin_sel_t   sel;
        logic [7:0] off;
        sel.hit = 1'b0;
        sel.bin = '0;
        off     = '0;
        if (c inside {[DIGIT0:DIGIT9]}) begin
            off     = c - DIGIT0;
            sel.hit = 1'b1;
            sel.bin = off[BIN_W-1:0];
        end else if (c inside {[CHAR_LA:CHAR_LZ]}) begin
            off     = c - CHAR_LA;
            sel.hit = 1'b1;
            sel.bin = BIN_W'(DIGIT_BINS) + {off[4:0], 1'b0};
        end else if (c inside {[CHAR_UA:CHAR_UZ]}) begin
            off     = c - CHAR_UA;
            sel.hit = 1'b1;
            sel.bin = BIN_W'(DIGIT_BINS) + {off[4:0], 1'b1};
        end
        return sel;
    endfunction

    function automatic logic [7:0] letter_of(input logic [LCUR_W-1:0] idx);
        logic [7:0] base;
        base = idx[0] ? CHAR_UA : CHAR_LA;
        return base + {3'b000, idx[LCUR_W-1:1]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/class_preserving_char_sort.sv -----
// ----------------------------------------------------------------------------
// class_preserving_char_sort
// Sorts the digits and the letters of a string within their own positions.
// ----------------------------------------------------------------------------
// Usage: a string enters on the s_ channel one byte per request, with s_tlast
// on its final byte. Up to MAX_LEN bytes are kept; later bytes are dropped, but
// a tlast on them still ends the string. Then the string leaves on the m_
// channel at the same length: digit positions carry the digits in ascending
// order, letter positions the letters in the order a,A,b,B,...,z,Z, and every
// other byte stays in place. m_tlast marks the final byte.
// Loading takes each byte that is neither letter nor digit directly; a letter
// or digit also goes through a read-modify-write of the count memory. For each
// byte, emission reads the store and classifies the byte; for a digit or a
// letter, the digit or letter cursor reads count-memory bins and moves past each
// bin whose count is used up (at most 62 bins per string). Emission begins once
// the final request has been taken.
// s_tready is low while a string is emitted. The m_ side has an output
// register, so a stall there holds the pending byte and pauses emission only.
// Reset empties the string and clears all counts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module class_preserving_char_sort
    import cpcs_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_char
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic            m_tlast
);

    localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_INC  = 3'd1;
    localparam logic [2:0] ST_RDB  = 3'd2;
    localparam logic [2:0] ST_CLS  = 3'd3;
    localparam logic [2:0] ST_CNT  = 3'd4;

    logic [7:0]       byte_mem [STORE_DEPTH];
    logic [CNT_W-1:0] cnt_mem  [NUM_BINS];

    logic [2:0]        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic              lastp_reg, lastp_next;
    logic [NUM_BINS-1:0] valid_reg, valid_next;
    logic [DCUR_W-1:0] dcur_reg, dcur_next;
    logic [LCUR_W-1:0] lcur_reg, lcur_next;
    logic              dheld_reg, dheld_next;
    logic              lheld_reg, lheld_next;
    logic              cnt_vld_reg, cnt_vld_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [BIN_W-1:0]  inc_bin_reg, inc_bin_next;
    logic [CNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]  lcnt_reg, lcnt_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic [7:0]        byte_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;

    logic              byte_we, byte_re, cnt_we, cnt_re;
    logic [BIN_W-1:0]  cnt_raddr;
    logic [CNT_W-1:0]  cnt_val;
    bin_sel_t          in_sel, st_sel;
    logic              st_digit, st_letter, out_free, emit, emit_last;
    logic [7:0]        emit_char;

    assign in_sel    = bin_of(s_tdata);
    assign st_sel    = bin_of(byte_rd_reg);
    assign st_digit  = st_sel.hit && (st_sel.bin < BIN_W'(DIGIT_BINS));
    assign st_letter = st_sel.hit && !st_digit;
    assign cnt_val   = cnt_vld_reg ? cnt_rd_reg : '0;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_last = ({1'b0, pos_reg} + LEN_W'(1)) == len_reg;

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        lastp_next    = lastp_reg;
        valid_next    = valid_reg;
        dcur_next     = dcur_reg;
        lcur_next     = lcur_reg;
        dheld_next    = dheld_reg;
        lheld_next    = lheld_reg;
        cnt_vld_next  = cnt_vld_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        inc_bin_next  = inc_bin_reg;
        dcnt_next     = dcnt_reg;
        lcnt_next     = lcnt_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        byte_we       = 1'b0;
        byte_re       = 1'b0;
        cnt_we        = 1'b0;
        cnt_re        = 1'b0;
        cnt_raddr     = in_sel.bin;
        emit          = 1'b0;
        emit_char     = byte_rd_reg;

        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    if (len_reg < MAX_LEN_L) begin
                        byte_we  = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                    end
                    if ((len_reg < MAX_LEN_L) && in_sel.hit) begin
                        cnt_re       = 1'b1;
                        cnt_raddr    = in_sel.bin;
                        inc_bin_next = in_sel.bin;
                        lastp_next   = s_tlast;
                        state_next   = ST_INC;
                    end else if (s_tlast) begin
                        state_next = ST_RDB;
                    end
                end
            end
            ST_INC: begin
                cnt_we                  = 1'b1;
                valid_next[inc_bin_reg] = 1'b1;
                state_next              = lastp_reg ? ST_RDB : ST_LOAD;
            end
            ST_RDB: begin
                byte_re    = 1'b1;
                state_next = ST_CLS;
            end
            ST_CLS: begin
                if (st_digit) begin
                    if (dheld_reg && (dcnt_reg != '0)) begin
                        emit_char = DIGIT0 + 8'(dcur_reg);
                        if (out_free) begin
                            emit      = 1'b1;
                            dcnt_next = dcnt_reg - CNT_W'(1);
                        end
                    end else if (dheld_reg) begin
                        dcur_next  = dcur_reg + DCUR_W'(1);
                        dheld_next = 1'b0;
                    end else begin
                        cnt_re     = 1'b1;
                        cnt_raddr  = BIN_W'(dcur_reg);
                        state_next = ST_CNT;
                    end
                end else if (st_letter) begin
                    if (lheld_reg && (lcnt_reg != '0)) begin
                        emit_char = letter_of(lcur_reg);
                        if (out_free) begin
                            emit      = 1'b1;
                            lcnt_next = lcnt_reg - CNT_W'(1);
                        end
                    end else if (lheld_reg) begin
                        lcur_next  = lcur_reg + LCUR_W'(1);
                        lheld_next = 1'b0;
                    end else begin
                        cnt_re     = 1'b1;
                        cnt_raddr  = BIN_W'(DIGIT_BINS) + lcur_reg;
                        state_next = ST_CNT;
                    end
                end else begin
                    emit = out_free;
                end
            end
            ST_CNT: begin
                if (st_digit) begin
                    dcnt_next  = cnt_val;
                    dheld_next = 1'b1;
                end else begin
                    lcnt_next  = cnt_val;
                    lheld_next = 1'b1;
                end
                state_next = ST_CLS;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (cnt_re) begin
            cnt_vld_next = valid_reg[cnt_raddr];
        end

        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = emit_char;
            m_tlast_next  = emit_last;
            if (emit_last) begin
                len_next   = '0;
                pos_next   = '0;
                dcur_next  = '0;
                lcur_next  = '0;
                dheld_next = 1'b0;
                lheld_next = 1'b0;
                valid_next = '0;
                state_next = ST_LOAD;
            end else begin
                pos_next   = pos_reg + ADDR_W'(1);
                state_next = ST_RDB;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            len_reg      <= '0;
            pos_reg      <= '0;
            lastp_reg    <= 1'b0;
            valid_reg    <= '0;
            dcur_reg     <= '0;
            lcur_reg     <= '0;
            dheld_reg    <= 1'b0;
            lheld_reg    <= 1'b0;
            cnt_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            lastp_reg    <= lastp_next;
            valid_reg    <= valid_next;
            dcur_reg     <= dcur_next;
            lcur_reg     <= lcur_next;
            dheld_reg    <= dheld_next;
            lheld_reg    <= lheld_next;
            cnt_vld_reg  <= cnt_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inc_bin_reg <= inc_bin_next;
        dcnt_reg    <= dcnt_next;
        lcnt_reg    <= lcnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (byte_we) begin
            byte_mem[len_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (byte_re) begin
            byte_rd_reg <= byte_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[inc_bin_reg] <= cnt_val + CNT_W'(1);
        end
        if (cnt_re) begin
            cnt_rd_reg <= cnt_mem[cnt_raddr];
        end
    end

    `ASSERT_IMP(a_len_bound, aclk, aresetn, 1'b1, len_reg <= MAX_LEN_L)
    `ASSERT_IMP(a_dcur_bound, aclk, aresetn, 1'b1, dcur_reg < DCUR_W'(DIGIT_BINS))
    `ASSERT_IMP(a_lcur_bound, aclk, aresetn, 1'b1, lcur_reg < LCUR_W'(LETTER_BINS))
    `ASSERT_IMP(a_pos_in_string, aclk, aresetn,
        (state_reg == ST_RDB) || (state_reg == ST_CLS) || (state_reg == ST_CNT),
        {1'b0, pos_reg} < len_reg)
    `ASSERT_NEXT(a_last_starts_emit, aclk, aresetn,
        s_tvalid && s_tready && s_tlast, state_reg != ST_LOAD)

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streaming check of the class-preserving character sorter.
// ----------------------------------------------------------------------------
// Strings are sent on the s_ channel in bursts with random gaps. Every
// accepted request feeds a local model that keeps the string and its digit
// and letter counts. On the final byte, that model produces the rearranged
// string. Each byte that leaves on the m_ channel is compared with the
// oldest predicted byte, while the receiver stalls on a changing pattern.
// A short directed part covers class boundaries and the byte extremes.
// Random strings follow, a few of them at and beyond the store depth.
// ----------------------------------------------------------------------------

module testbench;

    import cpcs_pkg::*;

    localparam int         MAX_LEN       = 64;
    localparam int         RANDOM_ITEMS  = 190;
    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         DRAIN_CYCLES  = 400;
    localparam int         REPORT_LIMIT  = 10;
    localparam logic [7:0] ASCII_ZERO    = 8'd48;
    localparam logic [7:0] ASCII_NINE    = 8'd57;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;

    typedef enum int {
        STR_MIXED,
        STR_DIGITS,
        STR_REPEAT,
        STR_RAW
    } str_kind_t;

    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_ALTERNATE
    } rx_mode_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    char_req_t  in_bytes[$];
    char_req_t  sorted_bytes[$];

    logic [7:0]       str_bytes [STORE_DEPTH];
    logic [CNT_W-1:0] bin_count [NUM_BINS];
    int               str_len = 0;

    logic     s_took     = 1'b0;
    int       burst_left = 1;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       error_count = 0;
    int       cycle_count = 0;

    class_preserving_char_sort u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bins 0..9 hold digits, bins 10..61 letters as a,A,b,B,...,z,Z.
    function automatic int char_bin(input logic [7:0] c);
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            return int'(c - ASCII_ZERO);
        end
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
            return DIGIT_BINS + 2 * int'(c - ASCII_LOWER_A);
        end
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            return DIGIT_BINS + 2 * int'(c - ASCII_UPPER_A) + 1;
        end
        return -1;
    endfunction

    task automatic sort_accept(input logic [7:0] ch, input logic last);
        int         b;
        int         dcur;
        int         lcur;
        logic [7:0] src;
        logic [7:0] res;
        char_req_t  outb;
        if (str_len < MAX_LEN) begin
            b = char_bin(ch);
            str_bytes[str_len] = ch;
            if (b >= 0) begin
                bin_count[b] = bin_count[b] + 1'b1;
            end
            str_len++;
        end
        if (last) begin
            dcur = 0;
            lcur = 0;
            for (int i = 0; i < str_len; i++) begin
                src = str_bytes[i];
                res = src;
                b = char_bin(src);
                if (b >= 0 && b < DIGIT_BINS) begin
                    while (dcur < DIGIT_BINS && bin_count[dcur] == 0) dcur++;
                    if (dcur < DIGIT_BINS) begin
                        bin_count[dcur] = bin_count[dcur] - 1'b1;
                        res = ASCII_ZERO + 8'(dcur);
                    end
                end else if (b >= DIGIT_BINS) begin
                    while (lcur < LETTER_BINS && bin_count[DIGIT_BINS + lcur] == 0) lcur++;
                    if (lcur < LETTER_BINS) begin
                        bin_count[DIGIT_BINS + lcur] = bin_count[DIGIT_BINS + lcur] - 1'b1;
                        res = ((lcur % 2) ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(lcur / 2);
                    end
                end
                outb.ch   = res;
                outb.last = (i == str_len - 1);
                sorted_bytes.push_back(outb);
            end
            for (int k = 0; k < NUM_BINS; k++) bin_count[k] = '0;
            str_len = 0;
        end
    endtask

    task automatic push_byte(input logic [7:0] ch, input logic last);
        char_req_t req;
        req.ch   = ch;
        req.last = last;
        in_bytes.push_back(req);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return ASCII_ZERO + 8'($urandom_range(0, 9));
        end else if (r < 6) begin
            return ASCII_LOWER_A + 8'($urandom_range(0, 25));
        end else if (r < 8) begin
            return ASCII_UPPER_A + 8'($urandom_range(0, 25));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_string(input int len, input str_kind_t kind);
        logic [7:0] ch;
        logic [7:0] fill;
        fill = pick_char();
        for (int i = 0; i < len; i++) begin
            case (kind)
                STR_DIGITS: ch = ASCII_ZERO + 8'($urandom_range(0, 9));
                STR_REPEAT: ch = fill;
                STR_RAW:    ch = 8'($urandom_range(0, 255));
                default:    ch = pick_char();
            endcase
            push_byte(ch, i == len - 1);
        end
    endtask

    initial begin
        for (int k = 0; k < NUM_BINS; k++) bin_count[k] = '0;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge aclk) begin
        char_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (in_bytes.size() != 0) begin
                nxt = in_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.ch;
                s_tlast  <= nxt.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern changes at random intervals.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(10, 120);
            m_tready <= 1'b1;
        end else begin
            rx_left <= rx_left - 1;
            case (rx_mode)
                RX_OPEN:      m_tready <= 1'b1;
                RX_LIGHT:     m_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:     m_tready <= ($urandom_range(0, 3) == 0);
                RX_ALTERNATE: m_tready <= ~m_tready;
                default:      m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        char_req_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                sort_accept(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (sorted_bytes.size() == 0) begin
                    error_count <= error_count + 1;
                    if (error_count < REPORT_LIMIT) begin
                        $display("unexpected byte %h last %b", m_tdata, m_tlast);
                    end
                end else begin
                    want = sorted_bytes.pop_front();
                    if (m_tdata !== want.ch || m_tlast !== want.last) begin
                        error_count <= error_count + 1;
                        if (error_count < REPORT_LIMIT) begin
                            $display("byte mismatch: expected %h last %b, got %h last %b",
                                     want.ch, want.last, m_tdata, m_tlast);
                        end
                    end
                end
            end
        end
    end

    initial begin
        logic [7:0] boundary [12];
        int         queued;
        int         str_idx;
        int         len;
        int         r;
        str_kind_t  kind;
        boundary = '{8'h2F, 8'h39, 8'h3A, 8'h40, 8'h41, 8'h5B,
                     8'h60, 8'h61, 8'h7B, 8'h5A, 8'h30, 8'h7A};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_byte(8'h30, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h7A, 1'b1);
        for (int i = 0; i < 12; i++) push_byte(boundary[i], i == 11);
        push_byte(8'h42, 1'b0);
        push_byte(8'h31, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h30, 1'b1);

        while (in_bytes.size() != 0 || s_tvalid || sorted_bytes.size() != 0) begin
            @(posedge aclk);
        end

        queued  = 0;
        str_idx = 0;
        while (queued < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            if (str_idx == 3) begin
                len = MAX_LEN;
            end else if (str_idx == 7) begin
                len = MAX_LEN + 3;
            end else if (r == 0) begin
                len = $urandom_range(MAX_LEN - 4, MAX_LEN + 8);
            end else if (r < 3) begin
                len = $urandom_range(13, 40);
            end else begin
                len = $urandom_range(1, 12);
            end
            r = $urandom_range(0, 9);
            kind = (r == 0) ? STR_DIGITS : (r == 1) ? STR_REPEAT :
                   (r == 2) ? STR_RAW : STR_MIXED;
            queue_string(len, kind);
            queued += len;
            str_idx++;
        end

        while (in_bytes.size() != 0 || s_tvalid || sorted_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
